// ===== sv/pidfd_pkg.sv =====
package pidfd_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_COEFF = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_POLE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX        = 3'd5;

    localparam int CFG_DATA_W = 24;

    // Sign codes for the error and the raw action
    localparam logic [1:0] SIGN_ZERO = 2'b00;
    localparam logic [1:0] SIGN_POS  = 2'b01;
    localparam logic [1:0] SIGN_NEG  = 2'b11;

    localparam logic signed [15:0] OUT_MIN_RESET = 16'sh8000;
    localparam logic signed [15:0] OUT_MAX_RESET = 16'sh7FFF;

    typedef struct packed {
        logic [15:0] target;
        logic [15:0] measured;
    } in_word_t;

    typedef struct packed {
        logic [15:0] drive;
        logic        limited;
    } out_word_t;

    typedef struct packed {
        logic [23:0] prop_gain;
        logic [23:0] integral_coeff;
        logic [23:0] deriv_pole;
        logic [23:0] deriv_gain;
        logic [15:0] out_min;
        logic [15:0] out_max;
    } cfg_t;

    // Products formed in the front stage, all signed Q.16
    typedef struct packed {
        logic [40:0] prop_prod;
        logic [41:0] integ_inc;
        logic [40:0] dmeas_prod;
        logic [1:0]  err_sign;
    } s1_word_t;

    typedef struct packed {
        logic        clipped;
        logic [31:0] value;
    } clamp_res_t;

    // Clamp a Q.16 value to integer limits; the upper test wins on inverted limits
    function automatic clamp_res_t clamp_q16(input logic signed [42:0] x,
                                             input logic signed [15:0] lo,
                                             input logic signed [15:0] hi);
        logic signed [42:0] hi_q;
        logic signed [42:0] lo_q;
        clamp_res_t         r;
        hi_q = {{11{hi[15]}}, hi, 16'h0000};
        lo_q = {{11{lo[15]}}, lo, 16'h0000};
        if (x > hi_q)
        begin
            r.clipped = 1'b1;
            r.value   = hi_q[31:0];
        end
        else if (x < lo_q)
        begin
            r.clipped = 1'b1;
            r.value   = lo_q[31:0];
        end
        else
        begin
            r.clipped = 1'b0;
            r.value   = x[31:0];
        end
        return r;
    endfunction

    function automatic logic [1:0] sign_code(input logic signed [42:0] x);
        logic [1:0] s;
        if (x[42])
            s = SIGN_NEG;
        else if (x == 43'sd0)
            s = SIGN_ZERO;
        else
            s = SIGN_POS;
        return s;
    endfunction

endpackage

// ===== sv/pidfd_front.sv =====
module pidfd_front
    import pidfd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  in_word_t sample,
    input  cfg_t     cfg,
    output s1_word_t s1
);

    logic signed [15:0] last_measured_reg;
    logic signed [16:0] last_error_reg;
    s1_word_t           s1_reg;
    s1_word_t           s1_next;

    logic signed [16:0] err;
    logic signed [17:0] err_sum;
    logic signed [16:0] dmeas;
    logic signed [23:0] prop_gain;
    logic signed [23:0] integral_coeff;
    logic signed [23:0] deriv_gain;
    logic signed [40:0] prop_prod;
    logic signed [41:0] integ_inc;
    logic signed [40:0] dmeas_prod;

    // Error, trapezoid sum and measurement change, and their gain products
    always_comb
    begin
        prop_gain      = $signed(cfg.prop_gain);
        integral_coeff = $signed(cfg.integral_coeff);
        deriv_gain     = $signed(cfg.deriv_gain);
        err     = $signed({sample.target[15], sample.target})
                - $signed({sample.measured[15], sample.measured});
        err_sum = $signed({err[16], err}) + $signed({last_error_reg[16], last_error_reg});
        dmeas   = $signed({sample.measured[15], sample.measured})
                - $signed({last_measured_reg[15], last_measured_reg});
        prop_prod  = prop_gain * err;
        integ_inc  = integral_coeff * err_sum;
        dmeas_prod = deriv_gain * dmeas;
        s1_next.prop_prod  = prop_prod;
        s1_next.integ_inc  = integ_inc;
        s1_next.dmeas_prod = dmeas_prod;
        s1_next.err_sign   = sign_code($signed({{26{err[16]}}, err}));
    end

    // Advance the sample history on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_measured_reg <= '0;
            last_error_reg    <= '0;
        end
        else if (load)
        begin
            last_measured_reg <= $signed(sample.measured);
            last_error_reg    <= err;
        end
    end

    // Hold the products for the loop stage
    always_ff @(posedge clk)
    begin
        if (load)
            s1_reg <= s1_next;
    end

    assign s1 = s1_reg;

endmodule

// ===== sv/pidfd_loop.sv =====
module pidfd_loop
    import pidfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  s1_word_t  s1,
    input  cfg_t      cfg,
    output out_word_t result
);

    logic signed [39:0] integral_reg;
    logic signed [39:0] deriv_reg;
    logic               limited_reg;
    logic [1:0]         sign_reg;
    out_word_t          result_reg;

    logic signed [39:0] integral_next;
    logic signed [39:0] deriv_next;
    logic [1:0]         sign_next;
    out_word_t          result_next;

    logic signed [23:0] pole;
    logic signed [23:0] d_hi;
    logic signed [16:0] d_lo;
    logic signed [47:0] hi_prod;
    logic signed [40:0] lo_prod;
    logic signed [48:0] pole_term;
    logic signed [49:0] deriv_raw;
    logic signed [42:0] integ_sum;
    logic signed [42:0] action;
    logic               freeze;
    clamp_res_t         integ_clamp;
    clamp_res_t         act_clamp;
    logic signed [40:0] prop_prod;
    logic signed [41:0] integ_inc;
    logic signed [40:0] dmeas_prod;

    always_comb
    begin
        prop_prod  = $signed(s1.prop_prod);
        integ_inc  = $signed(s1.integ_inc);
        dmeas_prod = $signed(s1.dmeas_prod);

        // Filter feedback split in two partial products; floor keeps the high part exact
        pole      = $signed(cfg.deriv_pole);
        d_hi      = deriv_reg[39:16];
        d_lo      = $signed({1'b0, deriv_reg[15:0]});
        hi_prod   = pole * d_hi;
        lo_prod   = pole * d_lo;
        pole_term = $signed({hi_prod[47], hi_prod})
                  + $signed({{24{lo_prod[40]}}, lo_prod[40:16]});
        deriv_raw = $signed({pole_term[48], pole_term})
                  + $signed({{9{dmeas_prod[40]}}, dmeas_prod});

        // Saturate the derivative term to its 40-bit range
        if (deriv_raw[49:39] == {11{deriv_raw[49]}})
            deriv_next = deriv_raw[39:0];
        else if (deriv_raw[49])
            deriv_next = {1'b1, 39'h0};
        else
            deriv_next = {1'b0, {39{1'b1}}};

        // Trapezoidal integral, frozen while pushing further into the limit
        freeze      = limited_reg && (sign_reg != SIGN_ZERO) && (sign_reg == s1.err_sign);
        integ_sum   = $signed({{3{integral_reg[39]}}, integral_reg})
                    + $signed({integ_inc[41], integ_inc});
        integ_clamp = clamp_q16(integ_sum, $signed(cfg.out_min), $signed(cfg.out_max));
        if (freeze)
            integral_next = integral_reg;
        else
            integral_next = $signed({{8{integ_clamp.value[31]}}, integ_clamp.value});

        // Sum the terms and clamp the action
        action = $signed({{2{prop_prod[40]}}, prop_prod})
               + $signed({{3{integral_next[39]}}, integral_next})
               + $signed({{3{deriv_next[39]}}, deriv_next});
        act_clamp = clamp_q16(action, $signed(cfg.out_min), $signed(cfg.out_max));
        sign_next = sign_code(action);

        result_next.drive   = act_clamp.value[31:16];
        result_next.limited = act_clamp.clipped;
    end

    // Advance the loop state once per word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            deriv_reg    <= '0;
            limited_reg  <= 1'b0;
            sign_reg     <= SIGN_ZERO;
        end
        else if (advance)
        begin
            integral_reg <= integral_next;
            deriv_reg    <= deriv_next;
            limited_reg  <= act_clamp.clipped;
            sign_reg     <= sign_next;
        end
    end

    // Hold the result word
    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign result = result_reg;

endmodule

// ===== sv/pid_filtered_derivative_antiwindup_core.sv =====
// Discrete PID controller with filtered derivative on the measurement and
// clamping anti-windup.
// Channels: sample (target, measured) in, result (drive, limited) out, both
// valid/ready; cfg writes one register per handshake: cfg_index selects
// prop_gain, integral_coeff, deriv_pole, deriv_gain, out_min, out_max
// (indexes 0 to 5, others ignored); limits take cfg_data[15:0]. cfg_ready is
// always high; write only while no word is in flight.
// An accepted sample is registered in the product stage, then in the result
// word, raising result_valid. Throughput: one word per cycle while results
// are taken. A product stage sits in front of the loop stage, whose feedback
// path (filter multiply, integral clamp, action clamp) sets the clock rate.
// Reset clears the gains, opens the limits to the full 16-bit range and zeroes
// the sample history, integral and derivative terms and the saturation flag.
// When the receiver stalls, the result word holds; one more sample is taken
// into the product stage, then sample_ready drops until the result is taken.
module pid_filtered_derivative_antiwindup_core
    import pidfd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_ready,
    input  in_word_t              sample,
    output logic                  result_valid,
    input  logic                  result_ready,
    output out_word_t             result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t     cfg_reg;
    logic     s1_valid_reg;
    logic     s1_valid_next;
    logic     out_valid_reg;
    logic     out_valid_next;
    logic     load;
    logic     advance;
    s1_word_t s1;

    // Pipeline handshake
    always_comb
    begin
        advance        = s1_valid_reg && (!out_valid_reg || result_ready);
        sample_ready   = !s1_valid_reg || advance;
        load           = sample_valid && sample_ready;
        s1_valid_next  = load || (s1_valid_reg && !advance);
        out_valid_next = advance || (out_valid_reg && !result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain      <= '0;
            cfg_reg.integral_coeff <= '0;
            cfg_reg.deriv_pole     <= '0;
            cfg_reg.deriv_gain     <= '0;
            cfg_reg.out_min        <= OUT_MIN_RESET;
            cfg_reg.out_max        <= OUT_MAX_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PROP_GAIN:      cfg_reg.prop_gain      <= cfg_data;
                CFG_INTEGRAL_COEFF: cfg_reg.integral_coeff <= cfg_data;
                CFG_DERIV_POLE:     cfg_reg.deriv_pole     <= cfg_data;
                CFG_DERIV_GAIN:     cfg_reg.deriv_gain     <= cfg_data;
                CFG_OUT_MIN:        cfg_reg.out_min        <= cfg_data[15:0];
                CFG_OUT_MAX:        cfg_reg.out_max        <= cfg_data[15:0];
                default:            ;
            endcase
        end
    end

    pidfd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (load),
        .sample (sample),
        .cfg    (cfg_reg),
        .s1     (s1)
    );

    pidfd_loop u_loop (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .s1      (s1),
        .cfg     (cfg_reg),
        .result  (result)
    );

    assign result_valid = out_valid_reg;

endmodule
